// File: rtl/ddq_pkg.sv
`default_nettype none

package ddq_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic        [OP_W-1:0]    op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  data;
      logic        [STATUS_W-1:0] status;
      logic        [COUNT_W-1:0]  count;
      logic                       is_empty;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/double_ended_queue.sv
`default_nettype none

// Double-ended queue of words in a circular single-port store of DEPTH
// entries, tracked by a front (head) pointer and an occupancy count.
// Each request transaction carries one operation (push/pop/peek at either
// end) and always yields exactly one response transaction with the word
// read, a status (ok, empty, full), the occupancy after the operation and
// an empty flag. Pops and peeks on an empty queue return status empty and
// zero data; a push into a full queue is dropped with status full; op codes
// six and seven do nothing and report the unchanged occupancy. Rate: one
// transaction per cycle while rsp_stall is low, through the issue stage and
// the response register; the rate is set by the store's single port, which
// each operation uses at most once. The store holds no reset value and
// needs no clearing pass; only occupied entries are ever read. Words are
// kept as the low DATA_WIDTH bits of the pushed value and returned
// zero-extended. count reports the low 11 bits of the occupancy.
module double_ended_queue
   import ddq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire     clock,
   input  wire     reset,

   input  wire     req_valid,
   output logic    req_stall,
   input  wire req_type req_data,

   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int SUM_W = OCC_W + 1;

   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   // response fields known at issue time; data joins from the store
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic                rd;
   } issue_type;

   // word store, one access per cycle, registered read
   logic [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_word_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic      s1_valid_ff, s1_valid_in;
   issue_type s1_ff, s1_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   logic                  accept, advance;
   logic                  full, empty;
   logic                  wr_en, rd_en;
   logic [PTR_W-1:0]      mem_addr;
   logic [DATA_WIDTH-1:0] wr_word;
   logic [SUM_W-1:0]      back_sum, last_sum, push_idx, last_idx;
   logic [PTR_W-1:0]      head_dec, head_inc;

   logic [DATA_WIDTH+VALUE_W-1:0] wr_ext;
   logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;
   logic [OCC_W+COUNT_W-1:0]      occ_ext;

   // response stage can take the issue stage this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   // no transaction is taken while in reset
   assign req_stall = reset || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign full  = (occ_ff == DEPTH_OCC);
   assign empty = (occ_ff == '0);

   // slot after the back, and the back itself, wrapped once
   assign back_sum = SUM_W'(head_ff) + SUM_W'(occ_ff);
   assign last_sum = back_sum - SUM_W'(1);
   assign push_idx = (back_sum >= DEPTH_SUM) ? back_sum - DEPTH_SUM : back_sum;
   assign last_idx = (last_sum >= DEPTH_SUM) ? last_sum - DEPTH_SUM : last_sum;
   assign head_dec = (head_ff == '0) ? LAST_PTR : head_ff - PTR_W'(1);
   assign head_inc = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);

   assign wr_ext  = {{DATA_WIDTH{1'b0}}, req_data.value};
   assign wr_word = wr_ext[DATA_WIDTH-1:0];

   always_comb begin
      head_in     = head_ff;
      occ_in      = occ_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      mem_addr    = head_ff;
      s1_in       = s1_ff;
      s1_in.status = ST_OK;
      s1_in.rd     = 1'b0;
      if (accept) begin
         unique case (req_data.op)
            OP_PUSH_BACK: begin
               if (full) begin
                  s1_in.status = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  mem_addr = push_idx[PTR_W-1:0];
                  occ_in   = occ_ff + OCC_W'(1);
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  s1_in.status = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  mem_addr = head_dec;
                  head_in  = head_dec;
                  occ_in   = occ_ff + OCC_W'(1);
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               if (empty) begin
                  s1_in.status = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  s1_in.rd = 1'b1;
                  mem_addr = head_ff;
                  if (req_data.op == OP_POP_FRONT) begin
                     head_in = head_inc;
                     occ_in  = occ_ff - OCC_W'(1);
                  end
               end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               if (empty) begin
                  s1_in.status = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  s1_in.rd = 1'b1;
                  mem_addr = last_idx[PTR_W-1:0];
                  if (req_data.op == OP_POP_BACK) begin
                     occ_in = occ_ff - OCC_W'(1);
                  end
               end
            end
            default: begin
               // unused codes: no-op
            end
         endcase
      end
      occ_ext        = {{COUNT_W{1'b0}}, occ_in};
      s1_in.count    = occ_ext[COUNT_W-1:0];
      s1_in.is_empty = (occ_in == '0);
   end

   // issue stage empties into the response register when it may advance
   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !advance);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_ext       = {{VALUE_W{1'b0}}, rd_word_ff};
      if (s1_valid_ff && advance) begin
         rsp_valid_in    = 1'b1;
         rsp_in.data     = s1_ff.rd ? rd_ext[VALUE_W-1:0] : '0;
         rsp_in.status   = s1_ff.status;
         rsp_in.count    = s1_ff.count;
         rsp_in.is_empty = s1_ff.is_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[mem_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         occ_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupancy never runs past the store size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_OCC)
      else $error("occupancy beyond depth");

   // head pointer stays inside the store
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_PTR)
      else $error("head pointer out of range");

   // a stalled issue stage must not be overwritten by a new transaction
   a_issue_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !accept)
      else $error("issue stage overwritten");

   // error, push and no-op responses carry zero data
   a_err_data: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && !s1_ff.rd) |=> (rsp_data.data == '0))
      else $error("non-zero data on response without read");

endmodule

`default_nettype wire
